// File: rtl/core/utc_pkg.sv
// Shared types, constants and helpers for the UTF-8 code point decoder.
package utc_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned ModW  = 4;
  localparam int unsigned ByteW = 8;

  // UTF-8 lead byte thresholds
  localparam logic [ByteW-1:0] Lead4Min = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Min = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Min = 8'hC0;

  localparam logic [CpW-1:0] SpaceCp = CpW'(32);
  localparam logic [CpW-1:0] DelCp   = CpW'(127);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // One decoded byte: up to two results, slot 0 (cut-short partial) goes first.
  typedef struct packed {
    logic [1:0]      vld;
    logic [CpW-1:0]  cp0;
    logic [CpW-1:0]  cp1;
    logic [ModW-1:0] mods;
  } entry_t;

  // Space, control codes and DEL are dropped.
  function automatic logic keep_cp(input logic [CpW-1:0] cp);
    keep_cp = !((cp <= SpaceCp) || (cp == DelCp));
  endfunction

endpackage

// File: rtl/core/utc_intf.sv
// Request and result channel interfaces of the UTF-8 decoder.
interface utc_req_if;
  import utc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic [ModW-1:0]  modifiers;
  logic             end_of_string;

  modport source (output valid, text_byte, modifiers, end_of_string, input ready);
  modport sink   (input valid, text_byte, modifiers, end_of_string, output ready);
endinterface

interface utc_res_if;
  import utc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CpW-1:0]  codepoint;
  logic [ModW-1:0] modifiers_out;
  logic            last_of_run;

  modport source (output valid, codepoint, modifiers_out, last_of_run, input ready);
  modport sink   (input valid, codepoint, modifiers_out, last_of_run, output ready);
endinterface

// File: rtl/core/utc_front.sv
// Front end: accepts bytes, tracks the pending sequence, builds result entries.
module utc_front import utc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic [ByteW-1:0] text_byte_i,
  input  logic [ModW-1:0]  modifiers_i,
  input  logic             end_of_string_i,
  input  logic             q_full_i,
  output logic             push_o,
  output entry_t           push_data_o
);

  logic [CpW-1:0] acc_q, acc_d;
  logic [1:0]     rem_q, rem_d;
  logic [CpW-1:0] acc_shift;
  logic [1:0]     rem_dec;
  logic [CpW-1:0] lead_cp;
  logic [1:0]     extra;
  logic           is_cont;
  logic           req_fire;
  entry_t         ent;

  assign req_ready_o = !q_full_i;
  assign req_fire    = req_valid_i && req_ready_o;

  always_comb begin
    is_cont   = (text_byte_i[7:6] == 2'b10);
    acc_shift = {acc_q[CpW-7:0], text_byte_i[5:0]};
    rem_dec   = rem_q - 2'd1;
    if (text_byte_i >= Lead4Min) begin
      lead_cp = CpW'(text_byte_i[2:0]);
      extra   = 2'd3;
    end else if (text_byte_i >= Lead3Min) begin
      lead_cp = CpW'(text_byte_i[3:0]);
      extra   = 2'd2;
    end else if (text_byte_i >= Lead2Min) begin
      lead_cp = CpW'(text_byte_i[4:0]);
      extra   = 2'd1;
    end else begin
      lead_cp = CpW'(text_byte_i);
      extra   = 2'd0;
    end

    acc_d    = acc_q;
    rem_d    = rem_q;
    ent      = '0;
    ent.mods = modifiers_i;

    if (rem_q != 2'd0 && is_cont) begin
      if (rem_dec == 2'd0 || end_of_string_i) begin
        ent.cp1    = acc_shift;
        ent.vld[1] = keep_cp(acc_shift);
        acc_d      = '0;
        rem_d      = 2'd0;
      end else begin
        acc_d = acc_shift;
        rem_d = rem_dec;
      end
    end else begin
      // a non-continuation byte flushes whatever was pending
      if (rem_q != 2'd0) begin
        ent.cp0    = acc_q;
        ent.vld[0] = keep_cp(acc_q);
      end
      if (extra != 2'd0 && !end_of_string_i) begin
        acc_d = lead_cp;
        rem_d = extra;
      end else begin
        ent.cp1    = lead_cp;
        ent.vld[1] = keep_cp(lead_cp);
        acc_d      = '0;
        rem_d      = 2'd0;
      end
    end
  end

  assign push_o      = req_fire && (ent.vld != 2'b00);
  assign push_data_o = ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      rem_q <= 2'd0;
    end else if (req_fire) begin
      acc_q <= acc_d;
      rem_q <= rem_d;
    end
  end

  // partial value never holds more bits than the bytes seen so far allow
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd0 |-> acc_q == '0)
    else $error("accumulator not clear while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd3 |-> acc_q[CpW-1:3] == '0)
    else $error("accumulator too wide after 4-byte lead");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd2 |-> acc_q[CpW-1:9] == '0)
    else $error("accumulator too wide with two bytes left");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q == 2'd1 |-> acc_q[CpW-1:15] == '0)
    else $error("accumulator too wide with one byte left");

endmodule

// File: rtl/core/utc_fifo.sv
// Small entry queue between decode front end and output back end.
module utc_fifo import utc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   pop_valid_o,
  output entry_t pop_data_o
);

  entry_t           mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o      = (cnt_q == QCntW'(QueueDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];

  function automatic logic [QPtrW-1:0] ptr_inc(input logic [QPtrW-1:0] p);
    ptr_inc = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + QPtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QCntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

// File: rtl/core/utc_back.sv
// Back end: drains queued entries one result per cycle onto the output while the result channel is ready.
module utc_back import utc_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            pop_valid_i,
  input  entry_t          pop_data_i,
  output logic            pop_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [CpW-1:0]  codepoint_o,
  output logic [ModW-1:0] modifiers_out_o,
  output logic            last_of_run_o
);

  logic [1:0]      vld_q, vld_d;
  logic [CpW-1:0]  cp0_q, cp1_q;
  logic [ModW-1:0] mods_q;
  logic            res_fire;
  logic            drained;

  assign res_valid_o     = (vld_q != 2'b00);
  assign codepoint_o     = vld_q[0] ? cp0_q : cp1_q;
  assign modifiers_out_o = mods_q;
  assign last_of_run_o   = (vld_q != 2'b11);
  assign res_fire        = res_valid_o && res_ready_i;
  assign drained         = !res_valid_o || (res_fire && last_of_run_o);
  assign pop_o           = pop_valid_i && drained;

  always_comb begin
    vld_d = vld_q;
    if (res_fire) begin
      vld_d = vld_q[0] ? {vld_q[1], 1'b0} : 2'b00;
    end
    if (pop_o) begin
      vld_d = pop_data_i.vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 2'b00;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cp0_q  <= pop_data_i.cp0;
      cp1_q  <= pop_data_i.cp1;
      mods_q <= pop_data_i.mods;
    end
  end

endmodule

// File: rtl/core/utf8_text_to_codepoints.sv
// Lenient UTF-8 decoder: text bytes in, filtered code points with modifiers out.
// Takes one byte per cycle. A byte yields zero, one or two code points; two
// only when a non-continuation byte (or end of string) cuts a
// pending sequence short and the byte then yields its own code point. The
// decode front end writes each byte's results into a two-entry queue, and the
// back end sends one result per cycle from its output register. The input
// takes a byte every cycle unless the queue is full, which only two-result
// bytes or a stalled result channel bring about; while it is full the input
// is held off even if the back end is draining an entry at the same time. A
// result passes through the queue and the back end's output register before
// it is presented; last_of_run marks the final result of each byte.
module utf8_text_to_codepoints import utc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  utc_req_if.sink   req_i,
  utc_res_if.source res_o
);

  logic   push, pop, q_full, q_valid;
  entry_t push_data, pop_data;

  utc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (req_i.valid),
    .req_ready_o     (req_i.ready),
    .text_byte_i     (req_i.text_byte),
    .modifiers_i     (req_i.modifiers),
    .end_of_string_i (req_i.end_of_string),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  utc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_i       (pop),
    .pop_valid_o (q_valid),
    .pop_data_o  (pop_data)
  );

  utc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (q_valid),
    .pop_data_i      (pop_data),
    .pop_o           (pop),
    .res_valid_o     (res_o.valid),
    .res_ready_i     (res_o.ready),
    .codepoint_o     (res_o.codepoint),
    .modifiers_out_o (res_o.modifiers_out),
    .last_of_run_o   (res_o.last_of_run)
  );

endmodule

// File: dv/utf8_codepoint_compare.sv
// Request/result watcher: predicts decoded code points and compares them with the DUT.
`timescale 1ns / 1ps
module utf8_codepoint_compare import utc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  utc_req_if   req_i,
  utc_res_if   res_i,
  output int   fail_count_o,
  output int   pending_o
);

  localparam logic [1:0]     ContTag   = 2'b10;
  localparam logic [CpW-1:0] SpaceCode = CpW'(32);
  localparam logic [CpW-1:0] DelCode   = CpW'(127);

  typedef struct packed {
    logic [CpW-1:0]  codepoint;
    logic [ModW-1:0] mods;
    logic            last;
  } cp_result_t;

  logic [CpW-1:0] acc_value;
  logic [1:0]     conts_left;
  cp_result_t     cp_expected[$];

  function automatic logic printable(input logic [CpW-1:0] cp);
    return (cp > SpaceCode) && (cp != DelCode);
  endfunction

  // Advance the decode state by one byte and queue what it should produce.
  task automatic decode_byte(input logic [ByteW-1:0] b, input logic [ModW-1:0] m,
                             input logic eos);
    logic [CpW-1:0] found[2];
    logic [CpW-1:0] cp;
    logic [1:0]     extra;
    cp_result_t     item;
    int             n;
    n = 0;
    if (conts_left != 2'd0 && b[7:6] == ContTag) begin
      acc_value  = {acc_value[CpW-7:0], b[5:0]};
      conts_left = conts_left - 2'd1;
      if (conts_left == 2'd0 || eos) begin
        if (printable(acc_value)) begin
          found[n] = acc_value;
          n++;
        end
        acc_value  = '0;
        conts_left = 2'd0;
      end
    end else begin
      // anything but a continuation flushes the partial value first
      if (conts_left != 2'd0) begin
        if (printable(acc_value)) begin
          found[n] = acc_value;
          n++;
        end
        acc_value  = '0;
        conts_left = 2'd0;
      end
      cp    = CpW'(b);
      extra = 2'd0;
      if (b >= Lead4Min) begin
        cp    = CpW'(b[2:0]);
        extra = 2'd3;
      end else if (b >= Lead3Min) begin
        cp    = CpW'(b[3:0]);
        extra = 2'd2;
      end else if (b >= Lead2Min) begin
        cp    = CpW'(b[4:0]);
        extra = 2'd1;
      end
      if (extra != 2'd0 && !eos) begin
        acc_value  = cp;
        conts_left = extra;
      end else if (printable(cp)) begin
        found[n] = cp;
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      item.codepoint = found[i];
      item.mods      = m;
      item.last      = (i == n - 1);
      cp_expected.push_back(item);
    end
  endtask

  always @(posedge clk_i) begin : watch
    cp_result_t want;
    if (!rst_ni) begin
      acc_value    = '0;
      conts_left   = 2'd0;
      fail_count_o = 0;
      cp_expected.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (cp_expected.size() == 0) begin
          $error("unexpected result: codepoint %0h modifiers_out %0h last_of_run %0b",
                 res_i.codepoint, res_i.modifiers_out, res_i.last_of_run);
          fail_count_o++;
        end else begin
          want = cp_expected.pop_front();
          if (res_i.codepoint !== want.codepoint) begin
            $error("codepoint: expected %0h, got %0h", want.codepoint, res_i.codepoint);
            fail_count_o++;
          end
          if (res_i.modifiers_out !== want.mods) begin
            $error("modifiers_out: expected %0h, got %0h", want.mods, res_i.modifiers_out);
            fail_count_o++;
          end
          if (res_i.last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, got %0b", want.last, res_i.last_of_run);
            fail_count_o++;
          end
        end
      end
      if (req_i.valid && req_i.ready) begin
        decode_byte(req_i.text_byte, req_i.modifiers, req_i.end_of_string);
      end
    end
    pending_o <= cp_expected.size();
  end

endmodule

// File: dv/utf8_text_to_codepoints_test.sv
// Top of the UTF-8 decoder testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module utf8_text_to_codepoints_test;
  import utc_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int HoldCycles  = 300;
  localparam int RandomBytes = 2000;
  localparam int PhaseCount  = 4;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_token;
  int   sent;

  utc_req_if text_req();
  utc_res_if cp_res();

  utf8_text_to_codepoints DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (text_req),
    .res_o (cp_res)
  );

  utf8_codepoint_compare u_compare (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req_i       (text_req),
    .res_i       (cp_res),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side: random stalls, plus a long hold-off whenever hold_token moves.
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    cp_res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        cp_res.ready <= 1'b0;
      end else begin
        cp_res.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b, input logic [ModW-1:0] m,
                           input logic eos);
    logic took;
    while ($urandom_range(99) < send_idle_pct) begin
      text_req.valid <= 1'b0;
      @(posedge clk);
    end
    text_req.valid         <= 1'b1;
    text_req.text_byte     <= b;
    text_req.modifiers     <= m;
    text_req.end_of_string <= eos;
    // ready is sampled mid-cycle, where it is settled for the coming edge
    do begin
      @(negedge clk);
      took = text_req.ready;
      @(posedge clk);
    end while (!took);
    sent++;
  endtask

  function automatic logic [ByteW-1:0] lead_byte(input int len);
    case (len)
      2:       return Lead2Min | ByteW'($urandom_range(31));
      3:       return Lead3Min | ByteW'($urandom_range(15));
      4:       return Lead4Min | ByteW'($urandom_range(15));
      default: return ByteW'($urandom_range(127));
    endcase
  endfunction

  // One string: mostly well-formed characters, some cut short, some raw noise.
  task automatic send_string();
    logic [ByteW-1:0] text[$];
    int chars;
    int kind;
    int len;
    int conts;
    chars = $urandom_range(1, 8);
    repeat (chars) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        len   = $urandom_range(1, 4);
        conts = len - 1;
        text.push_back(lead_byte(len));
      end else if (kind < 92) begin
        len   = $urandom_range(2, 4);
        conts = $urandom_range(0, len - 2);
        text.push_back(lead_byte(len));
      end else begin
        conts = 0;
        text.push_back(ByteW'($urandom_range(255)));
      end
      repeat (conts) text.push_back(8'h80 | ByteW'($urandom_range(63)));
    end
    foreach (text[i]) begin
      send_byte(text[i], ModW'($urandom_range(15)), i == text.size() - 1);
    end
  endtask

  initial begin : stimulus
    int target;
    rst_n                  <= 1'b0;
    text_req.valid         <= 1'b0;
    text_req.text_byte     <= '0;
    text_req.modifiers     <= '0;
    text_req.end_of_string <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_token     = 0;
    sent           = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // filtered values and plain ASCII
    send_byte(8'h00, 4'h0, 1'b0);
    send_byte(8'h20, 4'h1, 1'b0);
    send_byte(8'h7F, 4'h2, 1'b0);
    send_byte(8'h21, 4'h3, 1'b0);
    send_byte(8'h41, 4'hF, 1'b0);
    // lead at end of string, kept bits go out at once (and are filtered)
    send_byte(8'hFF, 4'h5, 1'b1);
    // two-byte sequence completing on the end of string
    send_byte(8'hC3, 4'h6, 1'b0);
    send_byte(8'hA9, 4'h7, 1'b1);
    // three- and four-byte sequences
    send_byte(8'hE2, 4'h8, 1'b0);
    send_byte(8'h82, 4'h9, 1'b0);
    send_byte(8'hAC, 4'hA, 1'b0);
    send_byte(8'hF0, 4'hB, 1'b0);
    send_byte(8'h9F, 4'hC, 1'b0);
    send_byte(8'h98, 4'hD, 1'b0);
    send_byte(8'h80, 4'hE, 1'b1);
    // cut short by ASCII: partial value, then the new byte
    send_byte(8'hE2, 4'h1, 1'b0);
    send_byte(8'h82, 4'h2, 1'b0);
    send_byte(8'h41, 4'h4, 1'b0);
    // stray continuation is a code point of its own
    send_byte(8'h80, 4'h3, 1'b0);
    // end of string on a continuation cuts the sequence
    send_byte(8'hE2, 4'h6, 1'b0);
    send_byte(8'h82, 4'h9, 1'b1);
    // zero byte cuts a pending sequence and is dropped
    send_byte(8'hD0, 4'hA, 1'b0);
    send_byte(8'h00, 4'h5, 1'b0);

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_token++;
        end
        1: begin
          send_idle_pct  = 62;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 62;
        end
        default: begin
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      target = sent + RandomBytes / PhaseCount;
      while (sent < target) send_string();
    end
    text_req.valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

endmodule
